// ===== rtl/core/icv2d_pkg.sv =====
// ----------------------------------------------------------------------------
// icv2d_pkg
// Shared widths, codes and types of the 2D convolution core.
// ----------------------------------------------------------------------------
`default_nettype none

package icv2d_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_KERNEL_ROWS_DEF = 5;
  localparam int unsigned MAX_KERNEL_COLS_DEF = 5;
  localparam int unsigned MAX_LINE_WIDTH_DEF  = 1024;

  localparam int unsigned MAX_IMG_HEIGHT = 1024;

  // Field widths.
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned KDIM_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned KREG_W     = 3;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CIDX_W     = 5;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned PROD_W     = 24;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 56;
  localparam int unsigned M_PAD_W    = M_TDATA_W - SUM_W - 2 * POS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH  = 2'd0,
    CFG_IMG_HEIGHT = 2'd1,
    CFG_KERN_ROWS  = 2'd2,
    CFG_KERN_COLS  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_e;

  // Configuration after clamping to the supported ranges.
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [KDIM_W-1:0] krows;
    logic [KDIM_W-1:0] kcols;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last;
  } meta_t;

  // One word moving through the front stages.
  typedef struct packed {
    logic              valid;
    logic              load;
    logic [CIDX_W-1:0] coef_index;
    logic [COEF_W-1:0] coef_value;
    logic              res_en;
    meta_t             meta;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    meta_t            meta;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/icv2d_cfg.sv =====
// ----------------------------------------------------------------------------
// icv2d_cfg
// Configuration registers with clamping of image and kernel sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module icv2d_cfg import icv2d_pkg::*; #(
  parameter int unsigned MAX_KERNEL_ROWS = MAX_KERNEL_ROWS_DEF,
  parameter int unsigned MAX_KERNEL_COLS = MAX_KERNEL_COLS_DEF,
  parameter int unsigned MAX_LINE_WIDTH  = MAX_LINE_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [DIM_W-1:0]  img_width_q, img_height_q;
  logic [KREG_W-1:0] kern_rows_q, kern_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= DIM_W'(1024);
      img_height_q <= DIM_W'(1024);
      kern_rows_q  <= KREG_W'(3);
      kern_cols_q  <= KREG_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_IMG_WIDTH:  img_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_IMG_HEIGHT: img_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_KERN_ROWS:  kern_rows_q  <= cfg_data_i[KREG_W-1:0];
        CFG_KERN_COLS:  kern_cols_q  <= cfg_data_i[KREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_width_q == '0) begin
      cfg_o.width = DIM_W'(1);
    end else if (int'(img_width_q) > int'(MAX_LINE_WIDTH)) begin
      cfg_o.width = DIM_W'(MAX_LINE_WIDTH);
    end else begin
      cfg_o.width = img_width_q;
    end

    if (img_height_q == '0) begin
      cfg_o.height = DIM_W'(1);
    end else if (int'(img_height_q) > int'(MAX_IMG_HEIGHT)) begin
      cfg_o.height = DIM_W'(MAX_IMG_HEIGHT);
    end else begin
      cfg_o.height = img_height_q;
    end

    if (kern_rows_q == '0) begin
      cfg_o.krows = KDIM_W'(1);
    end else if (int'(kern_rows_q) > int'(MAX_KERNEL_ROWS)) begin
      cfg_o.krows = KDIM_W'(MAX_KERNEL_ROWS);
    end else begin
      cfg_o.krows = KDIM_W'(kern_rows_q);
    end

    if (kern_cols_q == '0) begin
      cfg_o.kcols = KDIM_W'(1);
    end else if (int'(kern_cols_q) > int'(MAX_KERNEL_COLS)) begin
      cfg_o.kcols = KDIM_W'(MAX_KERNEL_COLS);
    end else begin
      cfg_o.kcols = KDIM_W'(kern_cols_q);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/icv2d_front.sv =====
// ----------------------------------------------------------------------------
// icv2d_front
// Raster counters, line buffer memory with write forwarding, and the
// pixel window shift registers.
// ----------------------------------------------------------------------------
`default_nettype none

module icv2d_front import icv2d_pkg::*; #(
  parameter int unsigned MAX_KERNEL_ROWS = MAX_KERNEL_ROWS_DEF,
  parameter int unsigned MAX_KERNEL_COLS = MAX_KERNEL_COLS_DEF,
  parameter int unsigned MAX_LINE_WIDTH  = MAX_LINE_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              accept_i,
  input  func_e                  func_i,
  input  wire logic [CIDX_W-1:0] coef_index_i,
  input  wire logic [COEF_W-1:0] coef_value_i,
  input  wire logic [PIX_W-1:0]  pixel_i,
  input  cfg_t                   cfg_i,
  output item_t                  item_o,
  output logic [MAX_KERNEL_ROWS-1:0][MAX_KERNEL_COLS-1:0][PIX_W-1:0] window_o
);

  localparam int unsigned CW   = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned CMPW = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int unsigned RW   = DIM_W + 1;
  localparam int unsigned LBW  = MAX_KERNEL_ROWS * PIX_W;

  logic [CW-1:0]    col_count_q, col_count_d;
  logic [POS_W-1:0] row_count_q, row_count_d;
  logic [CMPW-1:0]  col_nx, w_ext, kc_ext;
  logic [RW-1:0]    row_nx, h_ext, kr_ext;
  logic             col_ok, row_ok, col_end, row_end, pix_acc;

  item_t            s1_d, s1_q, s2_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_pixel;

  // Each line buffer word holds one column of the window, newest row lowest.
  logic [LBW-1:0] lb_mem [MAX_LINE_WIDTH];
  logic [LBW-1:0] rd_q, fwd_data_q, lb_rd, column;
  logic           fwd_q;

  logic [MAX_KERNEL_ROWS-1:0][MAX_KERNEL_COLS-1:0][PIX_W-1:0] win_q;

  assign pix_acc = accept_i && (func_i == FUNC_PIXEL);

  always_comb begin
    col_nx  = CMPW'(col_count_q) + CMPW'(1);
    w_ext   = CMPW'(cfg_i.width);
    kc_ext  = CMPW'(cfg_i.kcols);
    row_nx  = RW'(row_count_q) + RW'(1);
    h_ext   = RW'(cfg_i.height);
    kr_ext  = RW'(cfg_i.krows);
    col_ok  = col_nx >= kc_ext;
    row_ok  = row_nx >= kr_ext;
    col_end = col_nx >= w_ext;
    row_end = row_nx >= h_ext;

    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (pix_acc) begin
      if (col_end) begin
        col_count_d = '0;
        row_count_d = row_end ? '0 : row_nx[POS_W-1:0];
      end else begin
        col_count_d = col_nx[CW-1:0];
      end
    end

    s1_d.valid        = accept_i;
    s1_d.load         = (func_i == FUNC_LOAD);
    s1_d.coef_index   = coef_index_i;
    s1_d.coef_value   = coef_value_i;
    s1_d.res_en       = pix_acc && row_ok && col_ok;
    s1_d.meta.out_row = POS_W'(row_nx - kr_ext);
    s1_d.meta.out_col = POS_W'(col_nx - kc_ext);
    s1_d.meta.last    = row_end && col_end;
  end

  assign s1_pixel = s1_q.valid && !s1_q.load;
  assign lb_rd    = fwd_q ? fwd_data_q : rd_q;
  // The pixel enters at the bottom; each older row moves up by one byte.
  assign column   = LBW'({lb_rd, s1_pix_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      fwd_q       <= 1'b0;
      win_q       <= '0;
    end else if (en_i) begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
      s1_q        <= s1_d;
      s2_q        <= s1_q;
      // The word being written back this cycle is not yet in memory.
      fwd_q       <= pix_acc && s1_pixel && (s1_col_q == col_count_q);
      if (s1_pixel) begin
        for (int a = 0; a < MAX_KERNEL_ROWS; a++) begin
          for (int b = MAX_KERNEL_COLS - 1; b > 0; b--) begin
            win_q[a][b] <= win_q[a][b-1];
          end
          win_q[a][0] <= column[a*PIX_W +: PIX_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      rd_q     <= lb_mem[col_count_q];
      s1_pix_q <= pixel_i;
      s1_col_q <= col_count_q;
    end
    if (en_i) begin
      fwd_data_q <= column;
      if (s1_pixel) begin
        lb_mem[s1_col_q] <= column;
      end
    end
  end

  assign item_o   = s2_q;
  assign window_o = win_q;

`ifndef SYNTHESIS
  a_fwd_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_q.valid && !s1_q.load)
    else $error("line buffer forward without a pixel in the first stage");

  a_hold_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(col_count_q) && $stable(row_count_q))
    else $error("raster counters moved while the pipeline was stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/icv2d_mac.sv =====
// ----------------------------------------------------------------------------
// icv2d_mac
// Kernel store, one multiplier lane per window tap, and a registered
// adder tree that reduces the products to one sum.
// ----------------------------------------------------------------------------
`default_nettype none

module icv2d_mac import icv2d_pkg::*; #(
  parameter int unsigned MAX_KERNEL_ROWS = MAX_KERNEL_ROWS_DEF,
  parameter int unsigned MAX_KERNEL_COLS = MAX_KERNEL_COLS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  cfg_t      cfg_i,
  input  item_t     item_i,
  input  wire logic [MAX_KERNEL_ROWS-1:0][MAX_KERNEL_COLS-1:0][PIX_W-1:0] window_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  localparam int unsigned KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int unsigned EXT_W  = SUM_W - PROD_W;

  logic signed [COEF_W-1:0] kstore_q [KDEPTH];

  logic signed [PIX_W:0]        px;
  logic signed [PIX_W+COEF_W:0] full;
  logic signed [PROD_W-1:0]     prod_d [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];
  logic signed [PROD_W-1:0]     prod_q [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];
  logic [SUM_W-1:0]             rs_d [MAX_KERNEL_ROWS];
  logic [SUM_W-1:0]             rs_q [MAX_KERNEL_ROWS];
  logic [SUM_W-1:0]             total;

  logic  s3_vld_q, s4_vld_q;
  meta_t s3_meta_q, s4_meta_q;
  logic  item_pix;

  assign item_pix = item_i.valid && !item_i.load && item_i.res_en;

  // Window age (a,b) meets kernel entry (a,b), which flips the kernel.
  always_comb begin
    px   = '0;
    full = '0;
    for (int a = 0; a < MAX_KERNEL_ROWS; a++) begin
      for (int b = 0; b < MAX_KERNEL_COLS; b++) begin
        prod_d[a][b] = '0;
        if ((KDIM_W'(a) < cfg_i.krows) && (KDIM_W'(b) < cfg_i.kcols)) begin
          px           = $signed({1'b0, window_i[a][b]});
          full         = px * kstore_q[a*MAX_KERNEL_COLS + b];
          prod_d[a][b] = full[PROD_W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < MAX_KERNEL_ROWS; a++) begin
      rs_d[a] = '0;
      for (int b = 0; b < MAX_KERNEL_COLS; b++) begin
        rs_d[a] = rs_d[a] + {{EXT_W{prod_q[a][b][PROD_W-1]}}, prod_q[a][b]};
      end
    end
    total = '0;
    for (int a = 0; a < MAX_KERNEL_ROWS; a++) begin
      total = total + rs_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KDEPTH; k++) begin
        kstore_q[k] <= '0;
      end
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      // Loads pass through the same stage as the products, so pixels
      // ahead of a load still use the old coefficient.
      if (item_i.valid && item_i.load) begin
        for (int k = 0; k < KDEPTH; k++) begin
          if (int'(item_i.coef_index) == k) begin
            kstore_q[k] <= item_i.coef_value;
          end
        end
      end
      s3_vld_q <= item_pix;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      rs_q      <= rs_d;
      s3_meta_q <= item_i.meta;
      s4_meta_q <= s3_meta_q;
    end
  end

  assign res_valid_o = s4_vld_q;
  assign res_o.sum   = total;
  assign res_o.meta  = s4_meta_q;

endmodule

`default_nettype wire

// ===== rtl/core/icv2d_out.sv =====
// ----------------------------------------------------------------------------
// icv2d_out
// Output register with a skid entry; stalls the pipeline once the skid
// entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module icv2d_out import icv2d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  res_t      res_i,
  input  wire logic m_ready_i,
  output logic      en_o,
  output logic      m_valid_o,
  output res_t      m_data_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic push, take;

  assign en_o = !skid_valid_q;
  assign push = en_o && res_valid_i;
  assign take = out_valid_q && m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !m_ready_i |=> skid_valid_q && $stable(skid_q))
    else $error("skid entry lost or changed while the receiver stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/image_convolution_2d_core.sv =====
// ----------------------------------------------------------------------------
// image_convolution_2d_core
// Streaming valid-mode 2D convolution of a pixel raster with a stored kernel.
// ----------------------------------------------------------------------------
// Input words carry tuser = 0 to load one kernel coefficient (row-major index
// row*MAX_KERNEL_COLS+col) or tuser = 1 to deliver the next pixel in raster
// order. Once the window has kern_rows rows and kern_cols columns of the
// frame, every pixel yields one word: the signed sum of products with its
// output row and column, and tlast on the final window of the frame.
// Load words and early pixels give no output word.
// Throughput is one input word per cycle while the skid entry is empty.
// A result passes through the line buffer read, window shift, multiplier
// lanes, row-sum stage, then the output register. The user must write the
// configuration port only while the core is idle; the core does not enforce it.
// Reset restores the default sizes (1024 x 1024, 3 x 3 kernel), clears the
// kernel, the window and the raster counters; unwritten line buffer entries
// feed only taps that no output word uses, so the memory needs no clearing.
// When the receiver stalls, the output register holds its word and one more
// result goes into a skid entry; s_axis_tready then drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module image_convolution_2d_core import icv2d_pkg::*; #(
  parameter int unsigned MAX_KERNEL_ROWS = MAX_KERNEL_ROWS_DEF,
  parameter int unsigned MAX_KERNEL_COLS = MAX_KERNEL_COLS_DEF,
  parameter int unsigned MAX_LINE_WIDTH  = MAX_LINE_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // coef_index [4:0], coef_value [20:5], pixel [28:21], zeros above
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // func [0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // sum [28:0], out_row [38:29], out_col [48:39], zeros above
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t item;
  logic  en, accept, res_valid;
  res_t  res, m_data;
  logic [MAX_KERNEL_ROWS-1:0][MAX_KERNEL_COLS-1:0][PIX_W-1:0] window;

  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  icv2d_cfg #(
    .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS(MAX_KERNEL_COLS),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  icv2d_front #(
    .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS(MAX_KERNEL_COLS),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (accept),
    .func_i      (func_e'(s_axis_tuser)),
    .coef_index_i(s_axis_tdata[CIDX_W-1:0]),
    .coef_value_i(s_axis_tdata[CIDX_W +: COEF_W]),
    .pixel_i     (s_axis_tdata[CIDX_W+COEF_W +: PIX_W]),
    .cfg_i       (cfg),
    .item_o      (item),
    .window_o    (window)
  );

  icv2d_mac #(
    .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS(MAX_KERNEL_COLS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg),
    .item_i     (item),
    .window_i   (window),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  icv2d_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .m_ready_i  (m_axis_tready),
    .en_o       (en),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_data)
  );

  assign m_axis_tdata = {{M_PAD_W{1'b0}}, m_data.meta.out_col, m_data.meta.out_row,
                         m_data.sum};
  assign m_axis_tlast = m_data.meta.last;

endmodule

`default_nettype wire

// ===== test/tb_image_convolution_2d_core.sv =====
// ----------------------------------------------------------------------------
// tb_image_convolution_2d_core
// Self-checking testbench for the streaming 2D convolution core.
// ----------------------------------------------------------------------------
// Kernel loads and pixel words are driven on s_axis and mirrored in a local
// convolution predictor. Every output word is checked field by field against
// the oldest predicted sum. The sizes are changed only between whole frames.
// The run covers extreme coefficients, images smaller than the kernel,
// saturating size registers, frames at the full line width and height, and
// random frames under several patterns of source and sink back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_image_convolution_2d_core;
  timeunit 1ns;
  timeprecision 1ps;

  import icv2d_pkg::*;

  localparam int unsigned KR_MAX       = MAX_KERNEL_ROWS_DEF;
  localparam int unsigned KC_MAX       = MAX_KERNEL_COLS_DEF;
  localparam int unsigned LINE_MAX     = MAX_LINE_WIDTH_DEF;
  localparam int unsigned KSTORE_DEPTH = KR_MAX * KC_MAX;
  localparam int unsigned PIPE_SLACK   = 8;
  localparam int unsigned S_PAD_W      = S_TDATA_W - PIX_W - COEF_W - CIDX_W;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } conv_out_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the core state.
  logic signed [COEF_W-1:0] kern_mem [KSTORE_DEPTH];
  logic [PIX_W-1:0]         line_mem [KR_MAX][LINE_MAX];
  logic [PIX_W-1:0]         win_mem  [KR_MAX][KC_MAX];
  int unsigned              row_cnt;
  int unsigned              col_cnt;
  logic [DIM_W-1:0]         width_r;
  logic [DIM_W-1:0]         height_r;
  logic [KREG_W-1:0]        krows_r;
  logic [KREG_W-1:0]        kcols_r;

  conv_out_t conv_results_q [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned n_errors;
  int unsigned n_pixels;
  int unsigned n_loads;
  int unsigned n_frames;
  int unsigned n_sums;

  image_convolution_2d_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Advances the shadow state by one accepted word and queues its sum, if any.
  task automatic convolve_word(input func_e func, input logic [CIDX_W-1:0] idx,
                               input logic [COEF_W-1:0] val, input logic [PIX_W-1:0] pix);
    int unsigned w, h, kr, kc, col, row;
    logic [PIX_W-1:0] column [KR_MAX];
    longint acc;
    conv_out_t res;
    w  = clamp_size(width_r, LINE_MAX);
    h  = clamp_size(height_r, MAX_IMG_HEIGHT);
    kr = clamp_size(krows_r, KR_MAX);
    kc = clamp_size(kcols_r, KC_MAX);
    if (func == FUNC_LOAD) begin
      if (idx < KSTORE_DEPTH) kern_mem[idx] = val;
    end else begin
      col = (col_cnt < LINE_MAX) ? col_cnt : LINE_MAX - 1;
      row = row_cnt;
      // The new window column is this pixel plus the same column of older rows.
      column[0] = pix;
      for (int a = 1; a < KR_MAX; a++) column[a] = line_mem[a-1][col];
      for (int a = 0; a < KR_MAX; a++) begin
        line_mem[a][col] = column[a];
        for (int b = KC_MAX - 1; b > 0; b--) win_mem[a][b] = win_mem[a][b-1];
        win_mem[a][0] = column[a];
      end
      if (row + 1 >= kr && col + 1 >= kc) begin
        acc = 0;
        // Window age lines up with the kernel index, which flips the kernel.
        for (int a = 0; a < kr; a++) begin
          for (int b = 0; b < kc; b++) begin
            acc += longint'(win_mem[a][b]) * longint'(kern_mem[a*KC_MAX+b]);
          end
        end
        res.sum  = acc[SUM_W-1:0];
        res.row  = POS_W'(row + 1 - kr);
        res.col  = POS_W'(col + 1 - kc);
        res.last = (row + 1 >= h) && (col + 1 >= w);
        conv_results_q.push_back(res);
      end
      if (col + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col_cnt = col + 1;
      end
    end
  endtask

  task automatic send_word(input func_e func, input logic [CIDX_W-1:0] idx,
                           input logic [COEF_W-1:0] val, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{S_PAD_W{1'b0}}, pix, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    convolve_word(func, idx, val, pix);
    if (func == FUNC_PIXEL) begin
      n_pixels++;
    end else if (idx < KSTORE_DEPTH) begin
      n_loads++;
    end
  endtask

  task automatic send_load(input int unsigned idx, input logic [COEF_W-1:0] val);
    send_word(FUNC_LOAD, CIDX_W'(idx), val, PIX_W'($urandom));
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    send_word(FUNC_PIXEL, CIDX_W'($urandom), COEF_W'($urandom), pix);
  endtask

  // Holds the source off until every predicted sum has been seen, then lets
  // a load that is still in the pipeline settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (conv_results_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  task automatic set_image_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                  input logic [KREG_W-1:0] kr, input logic [KREG_W-1:0] kc);
    cfg_idx_e regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_IMG_WIDTH, CFG_IMG_HEIGHT, CFG_KERN_ROWS, CFG_KERN_COLS};
    vals = '{w, h, CFG_DATA_W'(kr), CFG_DATA_W'(kc)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (regs[i])
        CFG_IMG_WIDTH:  width_r  = vals[i][DIM_W-1:0];
        CFG_IMG_HEIGHT: height_r = vals[i][DIM_W-1:0];
        CFG_KERN_ROWS:  krows_r  = vals[i][KREG_W-1:0];
        CFG_KERN_COLS:  kcols_r  = vals[i][KREG_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_kernel();
    for (int unsigned i = 0; i < KSTORE_DEPTH; i++) send_load(i, rand_coef());
  endtask

  // One whole frame of random pixels, with the given percentage of stray loads mixed in and an optional drain halfway.
  task automatic send_frame(input int unsigned load_pct, input bit pause_mid);
    int unsigned npix;
    npix = clamp_size(width_r, LINE_MAX) * clamp_size(height_r, MAX_IMG_HEIGHT);
    for (int unsigned p = 0; p < npix; p++) begin
      if (pause_mid && p == npix / 2) drain_results();
      if ($urandom_range(99) < load_pct) send_load($urandom_range(31), rand_coef());
      send_pixel(rand_pixel());
    end
    n_frames++;
  endtask

  task automatic test_coef_extremes();
    set_image_config(3, 3, 3, 3);
    for (int unsigned r = 0; r < 3; r++) begin
      for (int unsigned c = 0; c < 3; c++) send_load(r * KC_MAX + c, 16'h8000);
    end
    // Indexes past the store must leave the kernel unchanged.
    send_load(KSTORE_DEPTH, 16'h7FFF);
    send_load((1 << CIDX_W) - 1, 16'h7FFF);
    repeat (9) send_pixel(8'hFF);
    n_frames++;
  endtask

  task automatic test_image_smaller_than_kernel();
    drain_results();
    set_image_config(2, 4, 3, 3);
    send_frame(0, 1'b0);
    drain_results();
    set_image_config(4, 2, 3, 3);
    send_frame(0, 1'b0);
  endtask

  task automatic test_random_frames(input int unsigned n_words);
    int unsigned start_cnt;
    bit paused;
    start_cnt = n_pixels + n_loads;
    paused    = 1'b0;
    while (n_pixels + n_loads - start_cnt < n_words) begin
      drain_results();
      set_image_config(DIM_W'($urandom_range(14)), DIM_W'($urandom_range(10)),
                       KREG_W'($urandom_range(7)), KREG_W'($urandom_range(7)));
      repeat ($urandom_range(1, 12)) send_load($urandom_range(31), rand_coef());
      send_frame(8, !paused);
      paused = 1'b1;
    end
  endtask

  // Full line width, full height and the saturating register values.
  task automatic test_frame_limits();
    drain_results();
    set_image_config(11'd2047, 11'd2, 3'd2, 3'd5);
    load_random_kernel();
    send_frame(0, 1'b0);
    drain_results();
    set_image_config(11'd1024, 11'd0, 3'd1, 3'd7);
    load_random_kernel();
    send_frame(0, 1'b0);
    drain_results();
    set_image_config(11'd0, 11'd2047, 3'd0, 3'd0);
    load_random_kernel();
    send_frame(0, 1'b0);
  endtask

  task automatic note_mismatch(input string what, input conv_out_t want, input conv_out_t got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR %s: expected sum %0d row %0d col %0d last %0b, got sum %0d row %0d col %0d last %0b",
               what, $signed(want.sum), want.row, want.col, want.last,
               $signed(got.sum), got.row, got.col, got.last);
    end
  endtask

  // Output checker and sink back-pressure.
  always @(posedge clk_i) begin
    conv_out_t got;
    conv_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sum  = m_axis_tdata[SUM_W-1:0];
      got.row  = m_axis_tdata[SUM_W +: POS_W];
      got.col  = m_axis_tdata[SUM_W+POS_W +: POS_W];
      got.last = m_axis_tlast;
      if (conv_results_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = conv_results_q.pop_front();
        if (got !== want) note_mismatch("sum mismatch", want, got);
        else n_sums++;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("FAIL image_convolution_2d_core");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_LOAD;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_IMG_WIDTH;
    cfg_data_i    <= '0;
    n_errors = 0;
    n_pixels = 0;
    n_loads  = 0;
    n_frames = 0;
    n_sums   = 0;
    src_idle_pct = 35;
    snk_idle_pct = 52;
    for (int a = 0; a < KR_MAX; a++) begin
      for (int b = 0; b < KC_MAX; b++) begin
        win_mem[a][b] = '0;
        kern_mem[a*KC_MAX+b] = '0;
      end
      for (int c = 0; c < LINE_MAX; c++) line_mem[a][c] = '0;
    end
    row_cnt  = 0;
    col_cnt  = 0;
    width_r  = DIM_W'(LINE_MAX);
    height_r = DIM_W'(MAX_IMG_HEIGHT);
    krows_r  = 3;
    kcols_r  = 3;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_coef_extremes();
    test_image_smaller_than_kernel();
    test_random_frames(350);
    src_idle_pct = 52;
    snk_idle_pct = 35;
    test_random_frames(350);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_frames(350);
    test_frame_limits();
    drain_results();

    $display("Sent %0d pixel words and %0d kernel loads in %0d frames; %0d sums matched.",
             n_pixels, n_loads, n_frames, n_sums);
    $display("Kernels 1x1 to 5x5, images up to 1024 wide or tall, with and without stalls.");
    if (n_errors == 0) begin
      $display("PASS image_convolution_2d_core");
    end else begin
      $display("FAIL image_convolution_2d_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
